@@ rtl/pdm_pkg.sv @@
// Shared types and constants for the PCM downmix and peak block.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package pdm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SUM_W        = 35;                 // signed frame sum
    localparam int DIV_STEPS    = SUM_W;              // one quotient bit a cycle
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int CNT_W        = 4;                  // channel_count width
    localparam int SB_W         = 3;                  // sample_bytes width

    localparam logic [SB_W-1:0]  SB_RESET  = 3'd2;
    localparam logic [CNT_W-1:0] CC_RESET  = 4'd1;
    localparam logic [CNT_W-1:0] CC_MAX    = 4'(MAX_CHANNELS);

    // register map index (paddr[2])
    localparam logic REG_SAMPLE_BYTES  = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef struct packed {
        logic [SB_W-1:0]  sample_bytes;
        logic [CNT_W-1:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;   // magnitude
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [31:0]      quotient;   // |sum|/cc never exceeds 2^31
    } t_div_rsp;

endpackage

@@ rtl/pcm_downmix_peak_core.sv @@
// Top level: byte-serial PCM unpack, channel downmix and buffer peak tracking.
// Depends on pdm_pkg, pdm_regs, pdm_div.
`timescale 1ns / 1ps

// Usage
//  - Input stream: one raw PCM byte per item on i_s_axis_tdata, tlast marks the
//    last byte of a buffer. Little endian signed samples, channels interleaved.
//  - Output stream: one item per completed frame and one per buffer end (both
//    at once when the last byte closes a frame). tdata = {peak_level, mono_sample},
//    tuser = {peak_valid, sample_valid}; fields not flagged read zero.
//  - Config: sample_bytes at 0x0, channel_count at 0x4. These are to be written
//    only while idle; that is up to the user, as the block has no check for it.
//  - A byte that ends neither frame nor buffer leaves tready high; a buffer-end
//    byte without a frame passes the emit state. A frame-closing byte runs the
//    divider, one quotient bit a cycle over the 35-bit sum, then emits the result.
//  - The block takes one item at a time; it is not ready while a frame divides.
//  - A full output register does not block intake: a new byte is accepted while
//    a result waits. Only a second result with the register still full stalls
//    the sequencer, which then holds tready low.
//  - Reset (synchronous, active low) clears framing, peak, output and registers
//    (sample_bytes 2, channel_count 1).

module pcm_downmix_peak_core
    import pdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] mono_sample, [63:32] peak_level
    output logic [1:0]  o_m_axis_tuser,   // [0] sample_valid, [1] peak_valid
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state           r_state;
    logic [23:0]      r_gather;
    logic [1:0]       r_byte_idx;
    logic [2:0]       r_chan_idx;
    logic [SUM_W-1:0] r_sum;
    logic [31:0]      r_peak;
    logic             r_neg;
    logic             r_last;
    logic             r_sv;
    logic [31:0]      r_mono;
    // output register
    logic             r_out_valid;
    logic [31:0]      r_out_mono;
    logic [31:0]      r_out_peak;
    logic             r_out_sv;
    logic             r_out_pv;

    pdm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- accept-cycle datapath ----------------
    logic             accept;
    logic [CNT_W-1:0] cc_sat;
    logic             fmt_ok;
    logic             sample_done;
    logic             frame_done;
    logic [31:0]      sample_q;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] sum_mag;
    logic [23:0]      n_gather;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_comb begin
        cc_sat = (cfg.channel_count > CC_MAX) ? CC_MAX : cfg.channel_count;
        fmt_ok = (cfg.sample_bytes >= 3'd2) && (cfg.sample_bytes <= 3'd4) &&
                 (cc_sat != '0);
        // sample completes once byte index reaches sample_bytes-1 (or passed it)
        sample_done = fmt_ok && !({1'b0, r_byte_idx} < (cfg.sample_bytes - 3'd1));
        frame_done  = sample_done && (({1'b0, r_chan_idx} + 4'd1) >= cc_sat);

        // align to Q1.31; stale gathered bytes above the sample drop out
        case (cfg.sample_bytes)
            3'd2:    sample_q = {i_s_axis_tdata, r_gather[7:0], 16'h0000};
            3'd3:    sample_q = {i_s_axis_tdata, r_gather[15:0], 8'h00};
            default: sample_q = {i_s_axis_tdata, r_gather[23:0]};
        endcase

        n_sum   = r_sum + {{(SUM_W-32){sample_q[31]}}, sample_q};
        sum_mag = n_sum[SUM_W-1] ? (SUM_W'(0) - n_sum) : n_sum;

        case (r_byte_idx)
            2'd0:    n_gather = r_gather | {16'h0000, i_s_axis_tdata};
            2'd1:    n_gather = r_gather | {8'h00, i_s_axis_tdata, 8'h00};
            default: n_gather = r_gather | {i_s_axis_tdata, 16'h0000};
        endcase
    end

    assign div_req.start    = accept & frame_done;
    assign div_req.dividend = sum_mag;
    assign div_req.divisor  = cc_sat;

    // ---------------- divider result ----------------
    logic [31:0] quo_mag;
    assign quo_mag = div_rsp.quotient;

    logic out_free;
    logic out_load;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign out_load = (r_state == ST_EMIT) && out_free;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gather    <= '0;
            r_byte_idx  <= '0;
            r_chan_idx  <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_neg       <= 1'b0;
            r_last      <= 1'b0;
            r_sv        <= 1'b0;
            r_mono      <= '0;
            r_out_valid <= 1'b0;
            r_out_mono  <= '0;
            r_out_peak  <= '0;
            r_out_sv    <= 1'b0;
            r_out_pv    <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_last <= i_s_axis_tlast;
                        r_sv   <= frame_done;
                        r_mono <= '0;
                        if (i_s_axis_tlast) begin
                            // buffer end: partial sample/frame is dropped
                            r_gather   <= '0;
                            r_byte_idx <= '0;
                            r_chan_idx <= '0;
                            r_sum      <= '0;
                        end else if (sample_done) begin
                            r_gather   <= '0;
                            r_byte_idx <= '0;
                            if (frame_done) begin
                                r_chan_idx <= '0;
                                r_sum      <= '0;
                            end else begin
                                r_chan_idx <= r_chan_idx + 3'd1;
                                r_sum      <= n_sum;
                            end
                        end else if (fmt_ok) begin
                            r_gather   <= n_gather;
                            r_byte_idx <= r_byte_idx + 2'd1;
                        end
                        if (frame_done) begin
                            r_neg   <= n_sum[SUM_W-1];
                            r_state <= ST_DIV;
                        end else if (i_s_axis_tlast) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end

                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_mono <= r_neg ? (32'd0 - quo_mag) : quo_mag;
                        if (quo_mag > r_peak) begin
                            r_peak <= quo_mag;
                        end
                        r_state <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_mono  <= r_mono;
                        r_out_sv    <= r_sv;
                        r_out_peak  <= r_last ? r_peak : 32'd0;
                        r_out_pv    <= r_last;
                        if (r_last) begin
                            r_peak <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_peak, r_out_mono};
    assign o_m_axis_tuser  = {r_out_pv, r_out_sv};

    // ---------------- assertions ----------------
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] || o_m_axis_tuser[1]))
        else $error("result item carries neither sample nor peak");

    a_unflagged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser[0] || o_m_axis_tdata[31:0] == 32'd0) &&
                             (o_m_axis_tuser[1] || o_m_axis_tdata[63:32] == 32'd0)))
        else $error("unflagged output field not zero");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= 32'h8000_0000)
        else $error("peak magnitude above full scale");

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule

@@ rtl/pdm_regs.sv @@
// APB-style configuration registers: sample_bytes and channel_count.
// Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_regs
    import pdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [SB_W-1:0]  r_sample_bytes;
    logic [CNT_W-1:0] r_channel_count;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bytes  <= SB_RESET;
            r_channel_count <= CC_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SAMPLE_BYTES:  r_sample_bytes  <= pwdata[SB_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SAMPLE_BYTES:  prdata = {{(32-SB_W){1'b0}}, r_sample_bytes};
            REG_CHANNEL_COUNT: prdata = {{(32-CNT_W){1'b0}}, r_channel_count};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.sample_bytes  = r_sample_bytes;
    assign o_cfg.channel_count = r_channel_count;

endmodule

@@ rtl/pdm_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned magnitude / channel count.
// Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_div
    import pdm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_work;     // dividend bits out the top, quotient in
    logic [CNT_W-1:0]     r_rem;      // always below the divisor
    logic [CNT_W-1:0]     r_divisor;

    logic [CNT_W:0] trial;
    logic           fits;

    assign trial = {r_rem, r_work[SUM_W-1]};
    assign fits  = trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_work    <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? CNT_W'(trial - {1'b0, r_divisor}) : trial[CNT_W-1:0];
                r_work <= {r_work[SUM_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work[31:0];

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for pcm_downmix_peak_core: byte stream in, mono/peak items out.
// Depends on rtl/pdm_pkg.sv and rtl/pcm_downmix_peak_core.sv; the bench keeps its own
// bit-exact model of the unpack, downmix and peak logic.
`timescale 1ns / 1ps

module tb_top;
    import pdm_pkg::*;

    localparam int ITEM_TARGET  = 1700;     // random items under a live format
    localparam int DRAIN_CYCLES = 60;       // extra wait once no results are owed
    localparam int PHASE_ITEMS  = 130;

    // one expected output item
    typedef struct packed {
        logic [31:0] peak;
        logic [31:0] mono;
        logic        pk_v;
        logic        smp_v;
    } t_downmix_res;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'd0;
    logic        s_last  = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = 3'd0;
    logic [31:0] pwdata  = 32'd0;

    logic        s_ready;
    logic        m_valid;
    logic [63:0] m_data;
    logic [1:0]  m_user;
    logic [31:0] prdata;
    logic        pready;

    // bench-side copy of the block state
    logic [2:0]  cfg_sample_bytes = SB_RESET;
    logic [3:0]  cfg_channels     = CC_RESET;
    logic [23:0] gather_q   = '0;
    logic [1:0]  byte_pos   = '0;
    logic [2:0]  chan_pos   = '0;
    longint      frame_sum  = 0;
    logic [31:0] peak_q     = '0;

    t_downmix_res downmix_q[$];   // results still owed by the block
    int  err_cnt    = 0;
    int  live_items = 0;          // items sent while the format was usable
    bit  idle_en    = 1'b1;       // random idling on both streams

    always #5 i_clk = ~i_clk;

    pcm_downmix_peak_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic bit format_ok();
        return cfg_sample_bytes >= 3'd2 && cfg_sample_bytes <= 3'd4 && cfg_channels != 4'd0;
    endfunction

    // Advance the model by one accepted byte; queue the result it owes, if any.
    task automatic predict_downmix(input logic [7:0] b, input logic last);
        logic [2:0]   sb;
        logic [3:0]   cc;
        logic [31:0]  merged, low_mask, word, aligned;
        longint       avg, mag;
        bit           got_smp;
        t_downmix_res r;
        sb      = cfg_sample_bytes;
        cc      = (cfg_channels > MAX_CHANNELS) ? CC_MAX : cfg_channels;
        got_smp = 1'b0;
        avg     = 0;
        if (sb >= 3'd2 && sb <= 3'd4 && cc != 4'd0) begin
            if ({1'b0, byte_pos} < sb - 3'd1) begin
                merged   = {8'd0, gather_q} | (32'(b) << (8 * byte_pos));
                gather_q = merged[23:0];
                byte_pos = byte_pos + 2'd1;
            end else begin
                // bytes gathered above the current width are masked off
                low_mask  = (32'd1 << (8 * (sb - 1))) - 32'd1;
                word      = ({8'd0, gather_q} & low_mask) | (32'(b) << (8 * (sb - 1)));
                aligned   = word << (8 * (4 - sb));
                frame_sum = frame_sum + longint'($signed(aligned));
                gather_q  = '0;
                byte_pos  = '0;
                if (int'(chan_pos) + 1 >= int'(cc)) begin
                    avg = frame_sum / longint'(cc);     // truncates toward zero
                    mag = (avg < 0) ? -avg : avg;
                    if (mag > longint'(peak_q))
                        peak_q = mag[31:0];
                    got_smp   = 1'b1;
                    chan_pos  = '0;
                    frame_sum = 0;
                end else begin
                    chan_pos = chan_pos + 3'd1;
                end
            end
        end
        if (got_smp || last) begin
            r.mono  = got_smp ? avg[31:0] : 32'd0;
            r.smp_v = got_smp;
            r.peak  = last ? peak_q : 32'd0;
            r.pk_v  = last;
            downmix_q = {downmix_q, r};
        end
        if (last) begin
            gather_q  = '0;
            byte_pos  = '0;
            chan_pos  = '0;
            frame_sum = 0;
            peak_q    = '0;
        end
    endtask

    // Send one byte; returns at the falling edge after it was taken, tvalid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        if (format_ok())
            live_items++;
        predict_downmix(b, last);
        @(negedge i_clk);
    endtask

    // Stop sending and let the block drain; the extra wait covers bytes with no result.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (downmix_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write with junk in the unused bits, then read back the masked value.
    task automatic program_reg(input logic idx, input logic [3:0] value);
        logic [31:0] mask, word;
        mask = (idx == REG_SAMPLE_BYTES) ? 32'h7 : 32'hF;
        word = ($urandom() & ~mask) | (32'(value) & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SAMPLE_BYTES)
            cfg_sample_bytes = word[2:0];
        else
            cfg_channels = word[3:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (word & mask))
            report_mismatch("register readback", prdata, word & mask);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output side: random stall bursts on m_ready while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted output item against the oldest expectation.
    always @(posedge i_clk) begin
        t_downmix_res want;
        if (i_rst_n && m_valid && m_ready) begin
            if (downmix_q.size() == 0) begin
                report_mismatch("item with nothing pending", m_data[31:0], 32'd0);
            end else begin
                want = downmix_q.pop_front();
                if (m_data[31:0] !== want.mono)
                    report_mismatch("mono_sample", m_data[31:0], want.mono);
                if (m_user[0] !== want.smp_v)
                    report_mismatch("sample_valid", 32'(m_user[0]), 32'(want.smp_v));
                if (m_data[63:32] !== want.peak)
                    report_mismatch("peak_level", m_data[63:32], want.peak);
                if (m_user[1] !== want.pk_v)
                    report_mismatch("peak_valid", 32'(m_user[1]), 32'(want.pk_v));
            end
        end
    end

    // Reset format (2 bytes, 1 channel): full-scale negative then full-scale positive.
    task automatic test_default_format();
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        settle_block();
    endtask

    // Bad widths and zero channels ignore bytes; tlast still reports and clears the peak.
    task automatic test_ignored_formats();
        send_byte(8'h00, 1'b0);
        send_byte(8'h40, 1'b0);
        settle_block();
        program_reg(REG_SAMPLE_BYTES, 4'd7);
        send_byte(8'h99, 1'b1);          // carries the peak built above
        settle_block();
        program_reg(REG_SAMPLE_BYTES, 4'd1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        settle_block();
        program_reg(REG_SAMPLE_BYTES, 4'd3);
        program_reg(REG_CHANNEL_COUNT, 4'd0);
        send_byte(8'h34, 1'b1);
        settle_block();
    endtask

    // Channel count above the maximum saturates; eight full-scale negatives hit the sum floor.
    task automatic test_channel_saturation();
        program_reg(REG_SAMPLE_BYTES, 4'd2);
        program_reg(REG_CHANNEL_COUNT, 4'd15);
        for (int i = 0; i < 2 * MAX_CHANNELS; i++)
            send_byte((i % 2) ? 8'h80 : 8'h00, i == 2 * MAX_CHANNELS - 1);
        settle_block();
    endtask

    // Format change with a sample and a frame half done: counters carry over.
    task automatic test_midframe_reconfig();
        program_reg(REG_SAMPLE_BYTES, 4'd3);
        program_reg(REG_CHANNEL_COUNT, 4'd3);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        settle_block();
        program_reg(REG_SAMPLE_BYTES, 4'd2);
        program_reg(REG_CHANNEL_COUNT, 4'd1);
        send_byte(8'h96, 1'b1);
        settle_block();
    endtask

    // tlast inside a frame drops the partial sample and frame.
    task automatic test_partial_frame_drop();
        program_reg(REG_SAMPLE_BYTES, 4'd3);
        program_reg(REG_CHANNEL_COUNT, 4'd2);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        settle_block();
    endtask

    // Buffers of whole frames with random content, some cut short, under the current format.
    task automatic stream_buffers(input int quota);
        logic [7:0]  pcm_q[$];
        logic [31:0] v, neg_full, pos_full;
        int          sb, cc_eff, frames, fkind, skind, extra, n;
        sb       = cfg_sample_bytes;
        cc_eff   = (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels;
        neg_full = 32'd1 << (8 * sb - 1);
        pos_full = neg_full - 32'd1;
        if (!format_ok()) begin
            repeat ($urandom_range(3, 8))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
            return;
        end
        n = 0;
        while (n < quota) begin
            pcm_q.delete();
            frames = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            for (int f = 0; f < frames; f++) begin
                fkind = $urandom_range(0, 7);       // 0/1: whole frame at one rail
                for (int c = 0; c < cc_eff; c++) begin
                    skind = (fkind < 2) ? fkind : $urandom_range(0, 9);
                    if (skind == 0)
                        v = neg_full;
                    else if (skind == 1)
                        v = pos_full;
                    else
                        v = $urandom();
                    for (int k = 0; k < sb; k++)
                        pcm_q = {pcm_q, v[8 * k +: 8]};
                end
            end
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sb * cc_eff - 1) : 0;
            repeat (extra)
                pcm_q = {pcm_q, 8'($urandom_range(0, 255))};
            if ($urandom_range(0, 9) == 0)          // broken buffer: tlast lands anywhere
                pcm_q = pcm_q[0 : $urandom_range(0, pcm_q.size() - 1)];
            foreach (pcm_q[i])
                send_byte(pcm_q[i], i == pcm_q.size() - 1);
            n += pcm_q.size();
        end
    endtask

    // Phases of random buffers; the first phases walk the format extremes.
    task automatic test_random_streams();
        logic [3:0] sb_pick[5] = '{4'd2, 4'd4, 4'd3, 4'd4, 4'd2};
        logic [3:0] cc_pick[5] = '{4'd1, 4'd8, 4'd15, 4'd1, 4'd8};
        logic [3:0] sb, cc;
        int         phase;
        phase = 0;
        while (live_items < ITEM_TARGET) begin
            settle_block();
            // no idling at all near the end of the run
            idle_en = (live_items < ITEM_TARGET - 200) && ($urandom_range(0, 3) != 0);
            if (phase < 5) begin
                sb = sb_pick[phase];
                cc = cc_pick[phase];
            end else if (phase % 6 == 5) begin
                if ($urandom_range(0, 1) == 0) begin
                    sb = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 1))
                                                     : 4'($urandom_range(5, 7));
                    cc = 4'($urandom_range(1, 8));
                end else begin
                    sb = 4'($urandom_range(2, 4));
                    cc = 4'd0;
                end
            end else begin
                sb = 4'($urandom_range(2, 4));
                cc = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(1, 8));
            end
            program_reg(REG_SAMPLE_BYTES, sb);
            program_reg(REG_CHANNEL_COUNT, cc);
            stream_buffers(PHASE_ITEMS);
            phase++;
        end
        settle_block();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_format();
        test_ignored_formats();
        test_channel_saturation();
        test_midframe_reconfig();
        test_partial_frame_drop();
        live_items = 0;
        test_random_streams();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && downmix_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pdm_pkg.sv
rtl/pdm_regs.sv
rtl/pdm_div.sv
rtl/pcm_downmix_peak_core.sv
sim/tb_top.sv
